/* rtl/core/hgc_pkg.sv */
`timescale 1ns / 1ps

package hgc_pkg;

   localparam int LatWidth    = 13;
   localparam int LonWidth    = 14;
   localparam int RadiusWidth = 18;
   localparam int DistWidth   = 23;
   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 18;

   localparam int DIST_FRAC_BITS_DEFAULT = 8;

   localparam int CordicWidth = 34;
   localparam int CordicSteps = 30;
   localparam int SqrtWidth   = 64;
   localparam int SqrtSteps   = 32;

   localparam logic [27:0] HalfRadPerArcminQ40 = 28'd159917484;
   localparam logic signed [CordicWidth-1:0] CordicGainQ30 = 34'sd652032874;
   localparam logic signed [CordicWidth-1:0] PiQ30         = 34'sd3373259426;
   localparam logic signed [CordicWidth-1:0] HalfPiQ30     = 34'sd1686629713;
   localparam logic [30:0] OneQ30      = 31'h4000_0000;
   localparam logic [12:0] EarthRadiusKm = 13'd6371;

   localparam logic [LatWidth-1:0]    HomeLatReset = 13'd601;
   localparam logic [LonWidth-1:0]    HomeLonReset = 14'd4892;
   localparam logic [RadiusWidth-1:0] RadiusReset  = 18'd51200;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_HOME_LAT = 2'd0,
      CSR_HOME_LON = 2'd1,
      CSR_RADIUS   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LonWidth-1:0] fix_lon_arcmin;
      logic [LatWidth-1:0] fix_lat_arcmin;
   } req_type;

   typedef struct packed {
      logic                 breach_event;
      logic                 outside_fence;
      logic [DistWidth-1:0] distance_q8;
   } rsp_type;

   typedef struct packed {
      logic signed [CordicWidth-1:0] x;
      logic signed [CordicWidth-1:0] y;
      logic signed [CordicWidth-1:0] z;
   } cordic_vec_type;

   typedef struct packed {
      logic [SqrtWidth-1:0] n;
      logic [SqrtWidth-1:0] r;
      logic [SqrtWidth-1:0] sq_bit;
   } sqrt_vec_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ANG_MUL,
      ST_ANG_LOAD,
      ST_ROT,
      ST_ROT_STORE,
      ST_SQ_LAT,
      ST_SQ_LON,
      ST_COS_PROD,
      ST_T2,
      ST_A,
      ST_ISQ_LOAD,
      ST_ISQ,
      ST_ISQ_STORE,
      ST_VEC_LOAD,
      ST_VEC,
      ST_DIST_MUL,
      ST_DIST,
      ST_OUT
   } state_type;

   function automatic logic signed [CordicWidth-1:0] atan_step(input logic [4:0] i);
      logic signed [CordicWidth-1:0] v;
      case (i)
         5'd0:  v = 34'sd843314857;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043837;
         5'd3:  v = 34'sd133525159;
         5'd4:  v = 34'sd67021687;
         5'd5:  v = 34'sd33543516;
         5'd6:  v = 34'sd16775851;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194283;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048576;
         5'd11: v = 34'sd524288;
         5'd12: v = 34'sd262144;
         5'd13: v = 34'sd131072;
         5'd14: v = 34'sd65536;
         default: v = $signed(34'd1 << (5'd30 - i));
      endcase
      return v;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [CordicWidth-1:0] v);
      logic signed [CordicWidth-1:0] m;
      m = (v < 0) ? -v : v;
      return m[31:0];
   endfunction

   function automatic logic [33:0] round_q30(input logic [63:0] p);
      logic [63:0] s;
      s = (p + 64'h2000_0000) >> 30;
      return s[33:0];
   endfunction

endpackage

/* rtl/core/hgc_mult.sv */
`timescale 1ns / 1ps

module hgc_mult
   import hgc_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] prod_ff
);

   logic [63:0] prod_in;

   assign prod_in = {32'd0, op_a} * {32'd0, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* rtl/core/hgc_cordic_step.sv */
`timescale 1ns / 1ps

module hgc_cordic_step
   import hgc_pkg::*;
(
   input  logic           vectoring,
   input  logic [4:0]     iter,
   input  cordic_vec_type cur,
   output cordic_vec_type nxt
);

   logic signed [CordicWidth-1:0] dx;
   logic signed [CordicWidth-1:0] dy;
   logic signed [CordicWidth-1:0] ang;
   logic                          dir;

   always_comb begin
      dx  = cur.y >>> iter;
      dy  = cur.x >>> iter;
      ang = atan_step(iter);
      dir = vectoring ? (cur.y < 0) : (cur.z >= 0);
      if (dir) begin
         nxt.x = cur.x - dx;
         nxt.y = cur.y + dy;
         nxt.z = cur.z - ang;
      end else begin
         nxt.x = cur.x + dx;
         nxt.y = cur.y - dy;
         nxt.z = cur.z + ang;
      end
   end

endmodule

/* rtl/core/hgc_isqrt_step.sv */
`timescale 1ns / 1ps

module hgc_isqrt_step
   import hgc_pkg::*;
(
   input  sqrt_vec_type cur,
   output sqrt_vec_type nxt
);

   logic [SqrtWidth-1:0] trial;

   always_comb begin
      trial = cur.r + cur.sq_bit;
      if (cur.n >= trial) begin
         nxt.n = cur.n - trial;
         nxt.r = (cur.r >> 1) + cur.sq_bit;
      end else begin
         nxt.n = cur.n;
         nxt.r = cur.r >> 1;
      end
      nxt.sq_bit = cur.sq_bit >> 2;
   end

endmodule

/* rtl/core/haversine_geofence_check_top.sv */
`timescale 1ns / 1ps
// An accepted request is worked through one shared CORDIC step unit (4 rotations and 1
// vectoring pass of 30 steps each), one shared square root step unit (2 roots of 32 steps)
// and a shared registered 32x32 multiplier. One transaction is in flight at a time; the
// request side is ready only when idle, and an unaccepted response holds the output state.
// Reset (synchronous, active high) restores the register defaults, clears the breach latch
// and empties the response.

module haversine_geofence_check_top
   import hgc_pkg::*;
#(
   parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   input  logic                    csr_we,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   localparam logic [63:0] DistRound = 64'd1 << (28 - DIST_FRAC_BITS);
   localparam int          DistShift = 29 - DIST_FRAC_BITS;
   localparam logic [63:0] DistMax   = 64'((64'd1 << DistWidth) - 64'd1);

   state_type state_ff, state_in;

   logic [LatWidth-1:0]    home_lat_ff;
   logic [LonWidth-1:0]    home_lon_ff;
   logic [RadiusWidth-1:0] radius_ff;
   logic                   latch_ff;

   logic [LatWidth-1:0]    fix_lat_ff;
   logic [LonWidth-1:0]    dlat_ff;
   logic [LonWidth-1:0]    dlon_ff;
   logic [1:0]             job_ff;
   logic [4:0]             iter_ff;
   logic                   flip_ff;
   logic                   sq_job_ff;
   cordic_vec_type         cv_ff, cv_in;
   sqrt_vec_type           sv_ff, sv_in;
   logic signed [CordicWidth-1:0] s_lat_ff, s_lon_ff, c1_ff, c2_ff;
   logic [33:0]            t1_ff, m1_ff;
   logic [30:0]            a_ff;
   logic [31:0]            h_ff, g_ff;
   logic [DistWidth-1:0]   dist_ff;

   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic [31:0]            op_a, op_b;
   logic [63:0]            prod_ff;
   logic                   vectoring;
   logic [14:0]            arc_sel;

   logic signed [CordicWidth-1:0] theta;
   logic signed [CordicWidth-1:0] cos_val;
   logic signed [35:0]            a_raw;
   logic [63:0]                   dist_full;
   logic                          outside;
   logic                          out_free;

   hgc_mult u_mult (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   hgc_cordic_step u_cordic (
      .vectoring (vectoring),
      .iter      (iter_ff),
      .cur       (cv_ff),
      .nxt       (cv_in)
   );

   hgc_isqrt_step u_isqrt (
      .cur (sv_ff),
      .nxt (sv_in)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_ANG_MUL;
         ST_ANG_MUL:   state_in = ST_ANG_LOAD;
         ST_ANG_LOAD:  state_in = ST_ROT;
         ST_ROT:       if (iter_ff == 5'(CordicSteps - 1)) state_in = ST_ROT_STORE;
         ST_ROT_STORE: state_in = (job_ff == 2'd3) ? ST_SQ_LAT : ST_ANG_MUL;
         ST_SQ_LAT:    state_in = ST_SQ_LON;
         ST_SQ_LON:    state_in = ST_COS_PROD;
         ST_COS_PROD:  state_in = ST_T2;
         ST_T2:        state_in = ST_A;
         ST_A:         state_in = ST_ISQ_LOAD;
         ST_ISQ_LOAD:  state_in = ST_ISQ;
         ST_ISQ:       if (iter_ff == 5'(SqrtSteps - 1)) state_in = ST_ISQ_STORE;
         ST_ISQ_STORE: state_in = sq_job_ff ? ST_VEC_LOAD : ST_ISQ_LOAD;
         ST_VEC_LOAD:  state_in = ST_VEC;
         ST_VEC:       if (iter_ff == 5'(CordicSteps - 1)) state_in = ST_DIST_MUL;
         ST_DIST_MUL:  state_in = ST_DIST;
         ST_DIST:      state_in = ST_OUT;
         ST_OUT:       if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      vectoring = 1'b0;
      op_a      = 32'd0;
      op_b      = 32'd0;
      case (job_ff)
         2'd0:    arc_sel = {2'd0, dlat_ff[LatWidth-1:0]};
         2'd1:    arc_sel = {1'b0, dlon_ff};
         2'd2:    arc_sel = {1'b0, home_lat_ff, 1'b0};
         default: arc_sel = {1'b0, fix_lat_ff, 1'b0};
      endcase
      unique case (state_ff)
         ST_ANG_MUL: begin
            op_a = {17'd0, arc_sel};
            op_b = {4'd0, HalfRadPerArcminQ40};
         end
         ST_SQ_LAT: begin
            op_a = mag32(s_lat_ff);
            op_b = mag32(s_lat_ff);
         end
         ST_SQ_LON: begin
            op_a = mag32(s_lon_ff);
            op_b = mag32(s_lon_ff);
         end
         ST_COS_PROD: begin
            op_a = mag32(c1_ff);
            op_b = mag32(c2_ff);
         end
         ST_T2: begin
            op_a = m1_ff[31:0];
            op_b = 32'(round_q30(prod_ff));
         end
         ST_VEC: vectoring = 1'b1;
         ST_DIST_MUL: begin
            op_a = cv_ff.z[CordicWidth-1] ? 32'd0 : cv_ff.z[31:0];
            op_b = {19'd0, EarthRadiusKm};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      theta     = $signed(34'((prod_ff + 64'd512) >> 10));
      cos_val   = flip_ff ? -cv_ff.x : cv_ff.x;
      a_raw     = (c1_ff[CordicWidth-1] != c2_ff[CordicWidth-1])
                  ? $signed({2'b00, t1_ff}) - $signed({2'b00, round_q30(prod_ff)})
                  : $signed({2'b00, t1_ff}) + $signed({2'b00, round_q30(prod_ff)});
      dist_full = (prod_ff + DistRound) >> DistShift;
      outside   = {5'd0, dist_ff} > radius_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         home_lat_ff  <= HomeLatReset;
         home_lon_ff  <= HomeLonReset;
         radius_ff    <= RadiusReset;
         latch_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         job_ff       <= 2'd0;
         iter_ff      <= 5'd0;
         sq_job_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_HOME_LAT: home_lat_ff <= csr_wdata[LatWidth-1:0];
               CSR_HOME_LON: home_lon_ff <= csr_wdata[LonWidth-1:0];
               CSR_RADIUS:   radius_ff   <= csr_wdata[RadiusWidth-1:0];
               default: begin
               end
            endcase
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               job_ff  <= 2'd0;
               iter_ff <= 5'd0;
            end
            ST_ROT, ST_ISQ, ST_VEC: iter_ff <= iter_ff + 5'd1;
            ST_ROT_STORE: begin
               job_ff    <= job_ff + 2'd1;
               sq_job_ff <= 1'b0;
            end
            ST_ISQ_LOAD: iter_ff <= 5'd0;
            ST_ISQ_STORE: begin
               sq_job_ff <= 1'b1;
               iter_ff   <= 5'd0;
            end
            ST_OUT: begin
               if (out_free) begin
                  if (outside) begin
                     latch_ff <= 1'b1;
                  end else if ({5'd0, dist_ff} < radius_ff) begin
                     latch_ff <= 1'b0;
                  end
               end
            end
            default: begin
               iter_ff <= 5'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            fix_lat_ff <= req_data.fix_lat_arcmin;
            dlat_ff <= (req_data.fix_lat_arcmin > home_lat_ff)
                       ? {1'b0, req_data.fix_lat_arcmin - home_lat_ff}
                       : {1'b0, home_lat_ff - req_data.fix_lat_arcmin};
            dlon_ff <= (req_data.fix_lon_arcmin > home_lon_ff)
                       ? req_data.fix_lon_arcmin - home_lon_ff
                       : home_lon_ff - req_data.fix_lon_arcmin;
         end
         ST_ANG_LOAD: begin
            cv_ff.x <= CordicGainQ30;
            cv_ff.y <= '0;
            if (theta > HalfPiQ30) begin
               cv_ff.z <= PiQ30 - theta;
               flip_ff <= 1'b1;
            end else begin
               cv_ff.z <= theta;
               flip_ff <= 1'b0;
            end
         end
         ST_ROT, ST_VEC: cv_ff <= cv_in;
         ST_ROT_STORE: begin
            case (job_ff)
               2'd0:    s_lat_ff <= cv_ff.y;
               2'd1:    s_lon_ff <= cv_ff.y;
               2'd2:    c1_ff    <= cos_val;
               default: c2_ff    <= cos_val;
            endcase
         end
         ST_SQ_LON:   t1_ff <= round_q30(prod_ff);
         ST_COS_PROD: m1_ff <= round_q30(prod_ff);
         ST_A: begin
            if (a_raw < 0) begin
               a_ff <= '0;
            end else if (a_raw > $signed({5'd0, OneQ30})) begin
               a_ff <= OneQ30;
            end else begin
               a_ff <= a_raw[30:0];
            end
         end
         ST_ISQ_LOAD: begin
            sv_ff.n      <= sq_job_ff ? {3'd0, OneQ30 - a_ff, 30'd0} : {3'd0, a_ff, 30'd0};
            sv_ff.r      <= '0;
            sv_ff.sq_bit <= 64'd1 << 62;
         end
         ST_ISQ: sv_ff <= sv_in;
         ST_ISQ_STORE: begin
            if (sq_job_ff) begin
               g_ff <= sv_ff.r[31:0];
            end else begin
               h_ff <= sv_ff.r[31:0];
            end
         end
         ST_VEC_LOAD: begin
            cv_ff.x <= $signed({2'b00, g_ff});
            cv_ff.y <= $signed({2'b00, h_ff});
            cv_ff.z <= '0;
         end
         ST_DIST: begin
            dist_ff <= (dist_full > DistMax) ? DistMax[DistWidth-1:0]
                                             : dist_full[DistWidth-1:0];
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_ff.distance_q8   <= dist_ff;
               rsp_ff.outside_fence <= outside;
               rsp_ff.breach_event  <= outside && !latch_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule
